### rtl/sts_pkg.sv
`timescale 1ns / 1ps
package sts_pkg;
  localparam int DEPTH = 16;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_LOADED  = 2'd0,
    ST_FULL    = 2'd1,
    ST_FOUND   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_PASS, S_MRD, S_MWAIT, S_MCMP, S_COPY, S_CWAIT, S_CWR,
    S_PROBE, S_PWAIT, S_PCMP, S_DONE
  } bstate_t;

  // Queue entry passed from front to back.
  typedef struct packed {
    logic        action;
    logic [31:0] operand;
  } cmd_t;
endpackage

### rtl/sts_if.sv
`timescale 1ns / 1ps
interface sts_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] operand;
  modport source (output valid, action, operand, input ready);
  modport sink (input valid, action, operand, output ready);
endinterface

interface sts_out_if (input logic clk);
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] position;
  modport source (output valid, status, position, input ready);
  modport sink (input valid, status, position, output ready);
endinterface

### rtl/sts_ram.sv
`timescale 1ns / 1ps
module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/sts_front.sv
`timescale 1ns / 1ps
module sts_front (
  input  logic            clk,
  input  logic            rst_n,
  sts_in_if.sink          in_ch,
  output sts_pkg::cmd_t   q_data,
  output logic            q_valid,
  input  logic            q_pop
);
  // Two-entry queue; accept whenever a slot is free.
  sts_pkg::cmd_t buf_r [2];
  logic          rd_r, wr_r;
  logic [1:0]    cnt_r;
  logic          push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) buf_r[wr_r] <= '{action: in_ch.action, operand: in_ch.operand ^ 32'h8000_0000};
    if (!rst_n) begin
      rd_r <= 1'b0;
      wr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (q_pop) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

### rtl/sts_back.sv
`timescale 1ns / 1ps
module sts_back (
  input  logic          clk,
  input  logic          rst_n,
  input  sts_pkg::cmd_t q_data,
  input  logic          q_valid,
  output logic          q_pop,
  sts_out_if.source     out_ch
);
  localparam int AW = sts_pkg::AW;
  localparam int CW = sts_pkg::CW;

  sts_pkg::bstate_t st_r, st_nxt;
  logic [CW-1:0] cnt_r;
  logic          sorted_r;
  logic [31:0]   key_r;
  logic [CW:0]   wid_r, mid_r, hi_r, l_r, r_r, w_r;
  logic [31:0]   lv_r;
  logic          phase_r;
  logic signed [CW+1:0] blo_r, bhi_r;
  logic [1:0]    stat_r;
  logic [AW-1:0] pos_r;
  logic          ovalid_r;

  // Table and scratch memories.
  logic          t_we, s_we;
  logic [AW-1:0] t_wa, t_ra, s_wa, s_ra;
  logic [31:0]   t_wd, t_rd, s_wd, s_rd;
  sts_ram #(.WIDTH(32), .DEPTH(sts_pkg::DEPTH)) u_tab (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  sts_ram #(.WIDTH(32), .DEPTH(sts_pkg::DEPTH)) u_scr (
    .clk(clk), .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));

  logic [CW:0] n_ext, mid_c, hi_c;
  logic signed [CW+1:0] bmid;
  logic l_live, r_live;
  assign n_ext = {1'b0, cnt_r};
  assign l_live = (l_r < mid_r);
  assign r_live = (r_r < hi_r);
  assign bmid = (blo_r + bhi_r) >>> 1;
  // Bounds of the next run pair.
  assign mid_c = hi_r + wid_r;
  assign hi_c = hi_r + (wid_r << 1);

  assign out_ch.valid = ovalid_r;
  assign out_ch.status = stat_r;
  assign out_ch.position = 4'(pos_r);
  assign q_pop = (st_r == sts_pkg::S_IDLE) && q_valid && !ovalid_r;

  // Next state.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      sts_pkg::S_IDLE:  if (q_pop) st_nxt = q_data.action ? sts_pkg::S_PASS : sts_pkg::S_LOAD;
      sts_pkg::S_LOAD:  st_nxt = sts_pkg::S_DONE;
      sts_pkg::S_PASS:  st_nxt = (sorted_r || wid_r >= n_ext) ? sts_pkg::S_PROBE : sts_pkg::S_MRD;
      sts_pkg::S_MRD:   st_nxt = sts_pkg::S_MWAIT;
      sts_pkg::S_MWAIT: st_nxt = sts_pkg::S_MCMP;
      sts_pkg::S_MCMP:  if (!phase_r) st_nxt = sts_pkg::S_MRD;
                        else if (w_r + 1 >= hi_r)
                          st_nxt = (hi_r >= n_ext) ? sts_pkg::S_COPY : sts_pkg::S_MRD;
                        else st_nxt = sts_pkg::S_MRD;
      sts_pkg::S_COPY:  st_nxt = sts_pkg::S_CWAIT;
      sts_pkg::S_CWAIT: st_nxt = sts_pkg::S_CWR;
      sts_pkg::S_CWR:   st_nxt = (w_r + 1 >= n_ext) ? sts_pkg::S_PASS : sts_pkg::S_COPY;
      sts_pkg::S_PROBE: st_nxt = (blo_r > bhi_r) ? sts_pkg::S_DONE : sts_pkg::S_PWAIT;
      sts_pkg::S_PWAIT: st_nxt = sts_pkg::S_PCMP;
      sts_pkg::S_PCMP:  st_nxt = (t_rd == key_r) ? sts_pkg::S_DONE : sts_pkg::S_PROBE;
      sts_pkg::S_DONE:  st_nxt = sts_pkg::S_IDLE;
      default:          st_nxt = sts_pkg::S_IDLE;
    endcase
  end

  // Memory controls; hold the read address through the wait cycle.
  always_comb begin
    t_we = 1'b0; s_we = 1'b0;
    t_wa = AW'(w_r); t_wd = s_rd; s_wa = AW'(w_r); s_wd = t_rd;
    t_ra = AW'(l_r); s_ra = AW'(w_r);
    unique case (st_r) inside
      sts_pkg::S_LOAD: begin
        t_we = (cnt_r < CW'(sts_pkg::DEPTH)); t_wa = AW'(cnt_r); t_wd = key_r;
      end
      sts_pkg::S_MRD, sts_pkg::S_MWAIT:
        t_ra = (phase_r || !l_live) ? AW'(r_r) : AW'(l_r);
      sts_pkg::S_MCMP: begin
        // phase 0 latched left head; phase 1 has right head in t_rd
        if (phase_r) begin
          s_we = 1'b1;
          if (l_live && (!r_live || lv_r <= t_rd)) s_wd = lv_r;
          else s_wd = t_rd;
        end
      end
      sts_pkg::S_CWR: t_we = 1'b1;
      sts_pkg::S_PROBE, sts_pkg::S_PWAIT: t_ra = AW'(bmid);
      default: ;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sts_pkg::S_IDLE;
      cnt_r <= '0;
      sorted_r <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      unique case (st_r)
        sts_pkg::S_IDLE: if (q_pop) begin
          key_r <= q_data.operand;
          wid_r <= (CW+1)'(1);
          pos_r <= '0;
          stat_r <= sts_pkg::ST_MISSING;
        end
        sts_pkg::S_LOAD: begin
          if (cnt_r < CW'(sts_pkg::DEPTH)) begin
            cnt_r <= cnt_r + 1'b1; sorted_r <= 1'b0; stat_r <= sts_pkg::ST_LOADED;
          end else stat_r <= sts_pkg::ST_FULL;
        end
        sts_pkg::S_PASS: begin
          blo_r <= '0;
          bhi_r <= $signed({2'b0, cnt_r}) - (CW+2)'(1);
          if (sorted_r || wid_r >= n_ext) sorted_r <= 1'b1;
          else begin
            l_r <= '0; w_r <= '0; phase_r <= 1'b0;
            mid_r <= (wid_r > n_ext) ? n_ext : wid_r;
            hi_r <= ((wid_r << 1) > n_ext) ? n_ext : (wid_r << 1);
            r_r <= (wid_r > n_ext) ? n_ext : wid_r;
          end
        end
        sts_pkg::S_MCMP: begin
          if (!phase_r) begin
            lv_r <= t_rd; phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
            if (l_live && (!r_live || lv_r <= t_rd)) l_r <= l_r + 1'b1;
            else r_r <= r_r + 1'b1;
            w_r <= w_r + 1'b1;
            if (w_r + 1 >= hi_r) begin
              l_r <= hi_r;
              mid_r <= (mid_c > n_ext) ? n_ext : mid_c;
              r_r <= (mid_c > n_ext) ? n_ext : mid_c;
              hi_r <= (hi_c > n_ext) ? n_ext : hi_c;
              if (hi_r >= n_ext) w_r <= '0;
            end
          end
        end
        sts_pkg::S_CWR: begin
          w_r <= w_r + 1'b1;
          if (w_r + 1 >= n_ext) wid_r <= wid_r << 1;
        end
        sts_pkg::S_PROBE: mid_r <= (CW+1)'(bmid);
        sts_pkg::S_PCMP: begin
          if (t_rd == key_r) begin
            stat_r <= sts_pkg::ST_FOUND; pos_r <= AW'(mid_r);
          end else if (key_r > t_rd) blo_r <= $signed({1'b0, mid_r}) + (CW+2)'(1);
          else bhi_r <= $signed({1'b0, mid_r}) - (CW+2)'(1);
        end
        sts_pkg::S_DONE: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end
endmodule

### rtl/sorted_table_search.sv
`timescale 1ns / 1ps
// Sorted table search.
// in channel: action 0 loads operand into the next table slot, action 1
// searches for operand. out channel: one transaction per input with status
// (loaded, full, found, not found) and the sorted position of a match.
// A two-entry queue decouples the input from the back-end sequencer, so
// inputs are taken while a result waits on a stalled receiver.
// A search runs a binary search over the sorted table; when loads arrived
// since the last search, a merge sort runs first over ceil(log2(n)) passes,
// paced by the one read port of the table memory (two heads read per merged
// entry). One item is processed at a time in the back end.
// Reset clears the entry count, marks the table sorted and empties the queue;
// table contents are undefined until loaded. A stalled out_ready holds the
// result and the back end; the queue then fills and in_ready drops.
module sorted_table_search (
  input logic clk,
  input logic rst_n,
  sts_in_if.sink    in_ch,
  sts_out_if.source out_ch
);
  sts_pkg::cmd_t q_data;
  logic          q_valid, q_pop;

  sts_front u_front (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop));
  sts_back u_back (.clk(clk), .rst_n(rst_n), .q_data(q_data), .q_valid(q_valid),
    .q_pop(q_pop), .out_ch(out_ch));

  // Pop only with data present.
  a_pop: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("queue popped while empty");
  // Result stays until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.status))
    else $error("result dropped");
endmodule

### tb/sv/sorted_table_search_tb.sv
`timescale 1ns / 1ps
module sorted_table_search_tb;

  typedef struct {
    logic        action;
    logic [31:0] operand;
  } item_t;

  typedef struct {
    sts_pkg::status_t status;
    logic [3:0]       position;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sts_in_if  in_ch (clk);
  sts_out_if out_ch (clk);

  sorted_table_search dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #10 clk = ~clk;

  // Predictor state: values held as signed words
  logic signed [31:0] tbl [sts_pkg::DEPTH];
  int                 tbl_count;
  bit                 tbl_sorted;

  item_t   pending_items [$];
  result_t expected_results [$];
  int      fail_count;
  bit      stim_done;
  int      send_idle_pct;
  int      recv_idle_pct;
  bit      in_taken;

  // Stable insertion sort gives the same order as a stable merge sort
  function automatic void sort_table();
    logic signed [31:0] v;
    int j;
    for (int i = 1; i < tbl_count; i++) begin
      v = tbl[i];
      j = i - 1;
      while (j >= 0 && tbl[j] > v) begin
        tbl[j + 1] = tbl[j];
        j--;
      end
      tbl[j + 1] = v;
    end
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    int lo, hi, mid;
    r.position = '0;
    if (it.action == 1'b0) begin
      if (tbl_count >= sts_pkg::DEPTH) begin
        r.status = sts_pkg::ST_FULL;
      end else begin
        tbl[tbl_count] = it.operand;
        tbl_count++;
        tbl_sorted = 1'b0;
        r.status = sts_pkg::ST_LOADED;
      end
    end else begin
      if (!tbl_sorted) begin
        sort_table();
        tbl_sorted = 1'b1;
      end
      r.status = sts_pkg::ST_MISSING;
      lo = 0;
      hi = tbl_count - 1;
      while (lo <= hi) begin
        mid = (lo + hi) / 2;
        if (tbl[mid] == $signed(it.operand)) begin
          r.status = sts_pkg::ST_FOUND;
          r.position = mid[3:0];
          break;
        end else if ($signed(it.operand) > tbl[mid]) begin
          lo = mid + 1;
        end else begin
          hi = mid - 1;
        end
      end
    end
    return r;
  endfunction

  // Driver: present the next pending item at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (!in_ch.valid || in_taken) begin
        if (in_taken) begin
          void'(pending_items.pop_front());
        end
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.action <= pending_items[0].action;
          in_ch.operand <= pending_items[0].operand;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on input transaction, check on result transaction
  always @(posedge clk) begin
    item_t   it;
    result_t exp_r;
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        it.action = in_ch.action;
        it.operand = in_ch.operand;
        expected_results.push_back(predict_result(it));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result status=%0d position=%0d",
                 out_ch.status, out_ch.position);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_ch.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.position !== exp_r.position) begin
            $error("position expected %0d actual %0d",
                   exp_r.position, out_ch.position);
            fail_count++;
          end
        end
      end
    end
  end

  function automatic logic [31:0] pick_value(int pool_sel);
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(7) - 3;
      default: return (pool_sel != 0) ? $urandom_range(15) : $urandom;
    endcase
  endfunction

  task automatic add_item(logic act, logic [31:0] op);
    item_t it;
    it.action = act;
    it.operand = op;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Random load/search mix over narrow and wide value pools
  task automatic add_random_block(int n);
    int narrow;
    for (int i = 0; i < n; i++) begin
      narrow = $urandom_range(1);
      if ($urandom_range(99) < 45) add_item(1'b0, pick_value(narrow));
      else add_item(1'b1, pick_value(narrow));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.action = 1'b0;
    in_ch.operand = '0;
    out_ch.ready = 1'b0;
    tbl_count = 0;
    tbl_sorted = 1'b1;
    fail_count = 0;
    stim_done = 1'b0;
    send_idle_pct = 34;
    recv_idle_pct = 75;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty search, extremes, duplicates, full table
    add_item(1'b1, 32'd0);
    add_item(1'b0, 32'h7fff_ffff);
    add_item(1'b0, 32'h8000_0000);
    add_item(1'b0, 32'd5);
    add_item(1'b0, 32'd5);
    add_item(1'b1, 32'h8000_0000);
    add_item(1'b1, 32'h7fff_ffff);
    add_item(1'b1, 32'd5);
    add_item(1'b1, 32'd4);
    add_item(1'b1, 32'hffff_ffff);
    for (int i = 0; i < 13; i++) add_item(1'b0, 32'hffff_fff0 + i);
    add_item(1'b1, 32'hffff_fffc);
    add_item(1'b1, 32'd5);

    // Random: table stays full after the first loads, so searches dominate
    add_random_block(500);
    wait_drained();
    send_idle_pct = 75;
    recv_idle_pct = 34;
    add_random_block(500);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_block(500);
    wait_drained();
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
